// ===== rtl/zcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// zcpd_pkg: shared types and constants of the zero-crossing pitch detector
// Status codes, sequencer states, divider sizing and the note threshold ladder.
// ----------------------------------------------------------------------------
`default_nettype none

package zcpd_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CountW  = 12;
  localparam int unsigned RateW   = 16;
  localparam int unsigned NoteW   = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivCntW = $clog2(RateW);
  localparam int unsigned NumBounds = 16;
  localparam int unsigned BoundW  = 9;

  localparam logic [SampleW-1:0] ZERO_LEVEL = SampleW'(128);

  // Result status codes
  typedef logic [StatusW-1:0] status_t;
  localparam status_t STATUS_NONE    = 2'd0;
  localparam status_t STATUS_PERIOD  = 2'd1;
  localparam status_t STATUS_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_PERIOD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PERIOD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [CountW-1:0] MIN_PERIOD_RST  = 12'd20;
  localparam logic [CountW-1:0] MAX_PERIOD_RST  = 12'd400;
  localparam logic [RateW-1:0]  SAMPLE_RATE_RST = 16'd8000;

  // Sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DIV,
    FSM_DONE
  } fsm_e;

  // Outcome of one tracker step
  typedef struct packed {
    status_t             status;
    logic [CountW-1:0]   period;
    logic [SampleW-1:0]  peak;
  } step_t;

  // Lower frequency bound of each note; the last entry is the top of the ladder
  localparam logic [BoundW-1:0] NOTE_BOUND [NumBounds] = '{
    9'd73,  9'd85,  9'd93,  9'd104, 9'd116, 9'd127, 9'd138, 9'd155,
    9'd169, 9'd185, 9'd207, 9'd233, 9'd254, 9'd277, 9'd311, 9'd349
  };

  // Class a frequency into a note, 0 when off the ladder
  function automatic logic [NoteW-1:0] note_of(input logic [RateW-1:0] freq);
    logic [NoteW-1:0] note;
    note = '0;
    for (int i = NumBounds - 1; i >= 1; i--) begin
      if (freq < {{(RateW-BoundW){1'b0}}, NOTE_BOUND[i]}) begin
        note = NoteW'(i);
      end
    end
    if (freq < {{(RateW-BoundW){1'b0}}, NOTE_BOUND[0]}) begin
      note = '0;
    end
    return note;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/zero_crossing_pitch_detector.sv =====
// ----------------------------------------------------------------------------
// zero_crossing_pitch_detector: period, note and peak from offset-128 samples
// Each accepted sample is registered with its tracker outcome; a found period
// then runs the 16-step divider, and the result goes to the output register.
// The input stalls until that result is loaded into the output register.
// A new sample is taken while the previous result still waits downstream.
// Reset: configuration returns to 20/400/8000, tracker state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_crossing_pitch_detector (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [zcpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [zcpd_pkg::RateW-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [zcpd_pkg::SampleW-1:0]   sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [zcpd_pkg::StatusW-1:0]        status_o,
  output logic [zcpd_pkg::CountW-1:0]         period_o,
  output logic [zcpd_pkg::NoteW-1:0]          note_o,
  output logic [zcpd_pkg::SampleW-1:0]        peak_amplitude_o
);
  import zcpd_pkg::*;

  logic [CountW-1:0]  min_period_q;
  logic [CountW-1:0]  max_period_q;
  logic [RateW-1:0]   sample_rate_q;

  fsm_e               state_q, state_d;
  logic               in_acc;
  logic               div_start;
  logic               div_done;
  logic               load_out;
  logic [RateW-1:0]   quotient;
  step_t              step;
  step_t              res_q;

  logic               out_valid_q, out_valid_d;
  status_t            status_q;
  logic [CountW-1:0]  period_q;
  logic [NoteW-1:0]   note_q;
  logic [SampleW-1:0] peak_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q  <= MIN_PERIOD_RST;
      max_period_q  <= MAX_PERIOD_RST;
      sample_rate_q <= SAMPLE_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_PERIOD:  min_period_q  <= cfg_data_i[CountW-1:0];
        CFG_MAX_PERIOD:  max_period_q  <= cfg_data_i[CountW-1:0];
        CFG_SAMPLE_RATE: sample_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;

  zcpd_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_acc),
    .sample_i     (sample_i),
    .min_period_i (min_period_q),
    .max_period_i (max_period_q),
    .step_o       (step)
  );

  zcpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sample_rate_q),
    .divisor_i  (step.period),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          state_d = (step.status == STATUS_PERIOD) ? FSM_DIV : FSM_DONE;
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (load_out) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i && (step.status == STATUS_PERIOD);
      end
      FSM_DIV: ;
      FSM_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the step outcome while the divider runs
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= step;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= res_q.status;
      period_q <= res_q.period;
      note_q   <= (res_q.status == STATUS_PERIOD) ? note_of(quotient) : '0;
      peak_q   <= res_q.peak;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign period_o         = period_q;
  assign note_o           = note_q;
  assign peak_amplitude_o = peak_q;

  // Divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == FSM_DIV)
    else $error("divider done outside of divide state");

  // An accepted beat always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != FSM_IDLE)
    else $error("sequencer stayed idle after accepting a beat");

  // Period and note are zero unless a valid period is reported
  a_no_period_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_PERIOD) |-> (period_o == '0 && note_o == '0))
    else $error("period or note set without a valid period");

  // Peak magnitude cannot exceed the offset
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_amplitude_o <= ZERO_LEVEL)
    else $error("peak magnitude out of range");

endmodule

`default_nettype wire

// ===== rtl/zcpd_div.sv =====
// ----------------------------------------------------------------------------
// zcpd_div: restoring divider, one quotient bit per cycle
// Divides the sample rate by the period; a zero divisor yields all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module zcpd_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [zcpd_pkg::RateW-1:0]  dividend_i,
  input  wire logic [zcpd_pkg::CountW-1:0] divisor_i,
  output logic                             done_o,
  output logic [zcpd_pkg::RateW-1:0]       quotient_o
);
  import zcpd_pkg::*;

  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [RateW-1:0]    quo_q, quo_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   dvs_q, dvs_d;
  logic [CountW:0]     trial;
  logic                fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[RateW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[RateW-2:0], fits};
      rem_d = fits ? CountW'(trial - {1'b0, dvs_q}) : trial[CountW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(RateW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && (cnt_q == DivCntW'(RateW - 1));
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/zcpd_track.sv =====
// ----------------------------------------------------------------------------
// zcpd_track: crossing and peak tracker
// Counts samples since the last positive crossing and keeps the peak magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module zcpd_track (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [zcpd_pkg::SampleW-1:0] sample_i,
  input  wire logic [zcpd_pkg::CountW-1:0]  min_period_i,
  input  wire logic [zcpd_pkg::CountW-1:0]  max_period_i,
  output zcpd_pkg::step_t                   step_o
);
  import zcpd_pkg::*;

  logic [SampleW-1:0] prev_q, prev_d;
  logic [SampleW-1:0] peak_q, peak_d;
  logic [CountW-1:0]  tick_q, tick_d;
  logic               seen_q, seen_d;
  logic [CountW-1:0]  tick_inc;
  logic [SampleW-1:0] mag;
  logic [SampleW-1:0] peak_base;
  logic               rising;

  assign tick_inc = tick_q + 1'b1;
  assign mag      = (sample_i >= ZERO_LEVEL) ? (sample_i - ZERO_LEVEL)
                                             : (ZERO_LEVEL - sample_i);
  assign rising   = (sample_i >= ZERO_LEVEL) && (prev_q < ZERO_LEVEL);

  // Decide the step outcome and the next tracker state
  always_comb begin
    step_o.status = STATUS_NONE;
    step_o.period = '0;
    tick_d        = tick_inc;
    seen_d        = seen_q;
    peak_base     = peak_q;
    if (tick_inc < min_period_i) begin
      step_o.status = STATUS_NONE;
    end else if (tick_inc >= max_period_i) begin
      step_o.status = STATUS_TIMEOUT;
      tick_d        = '0;
      seen_d        = 1'b0;
      peak_base     = '0;
    end else if (rising) begin
      if (seen_q) begin
        step_o.status = STATUS_PERIOD;
        step_o.period = tick_inc;
      end
      tick_d    = '0;
      seen_d    = 1'b1;
      peak_base = '0;
    end
    peak_d      = (mag > peak_base) ? mag : peak_base;
    prev_d      = sample_i;
    step_o.peak = peak_d;
  end

  // Advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= ZERO_LEVEL;
      peak_q <= '0;
      tick_q <= '0;
      seen_q <= 1'b0;
    end else if (step_i) begin
      prev_q <= prev_d;
      peak_q <= peak_d;
      tick_q <= tick_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_zero_crossing_pitch_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zero_crossing_pitch_detector: self-checking bench for the pitch detector
// Feeds offset-128 sample beats, mostly square-ish waves of random period and
// amplitude mixed with noise, under several register settings. An in-bench
// tracker predicts status, period, note and peak for every sample; each output
// beat is checked against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_zero_crossing_pitch_detector;
  import zcpd_pkg::*;

  localparam int unsigned RUN_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 24;
  // unmapped register index, the block has to ignore writes to it
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    status_t             status;
    logic [CountW-1:0]   period;
    logic [NoteW-1:0]    note;
    logic [SampleW-1:0]  peak;
  } pitch_beat_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [RateW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic [SampleW-1:0] sample_i    = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  period_o;
  logic [NoteW-1:0]   note_o;
  logic [SampleW-1:0] peak_amplitude_o;

  zero_crossing_pitch_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .period_o         (period_o),
    .note_o           (note_o),
    .peak_amplitude_o (peak_amplitude_o)
  );

  always #1 clk_i = ~clk_i;

  // Tracker copy: registers and detection state
  logic [CountW-1:0]  min_span    = MIN_PERIOD_RST;
  logic [CountW-1:0]  max_span    = MAX_PERIOD_RST;
  logic [RateW-1:0]   rate_hz     = SAMPLE_RATE_RST;
  logic [SampleW-1:0] last_sample = ZERO_LEVEL;
  logic [SampleW-1:0] peak_mag    = '0;
  logic [CountW-1:0]  tick_run    = '0;
  bit                 armed       = 1'b0;

  pitch_beat_t pending_pitch_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          sender_idle_en = 1'b0;
  bit          rx_stall_en    = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned stall_left     = 0;

  // Lower frequency edge of each ladder step
  function automatic int unsigned note_floor(int unsigned i);
    case (i)
      0: return 73;    1: return 85;    2: return 93;    3: return 104;
      4: return 116;   5: return 127;   6: return 138;   7: return 155;
      8: return 169;   9: return 185;   10: return 207;  11: return 233;
      12: return 254;  13: return 277;  14: return 311;  default: return 349;
    endcase
  endfunction

  // Divide the period into the rate and find the ladder step, 0 off the ladder
  function automatic logic [NoteW-1:0] note_for_period(logic [CountW-1:0] span);
    int unsigned freq;
    logic [NoteW-1:0] note;
    note = '0;
    if (span != '0) begin
      freq = rate_hz / span;
      if (freq >= note_floor(0)) begin
        for (int i = 15; i >= 1; i--) begin
          if (freq < note_floor(i)) note = NoteW'(i);
        end
      end
    end
    return note;
  endfunction

  // Advance the tracker by one sample and return the beat it should produce
  function automatic pitch_beat_t track_pitch(logic [SampleW-1:0] s);
    pitch_beat_t r;
    logic [SampleW-1:0] mag;
    r = '0;
    r.status = STATUS_NONE;
    tick_run = tick_run + 1'b1;
    if (tick_run >= min_span) begin
      if (tick_run >= max_span) begin
        r.status = STATUS_TIMEOUT;
        armed    = 1'b0;
        peak_mag = '0;
        tick_run = '0;
      end else if (s >= ZERO_LEVEL && last_sample < ZERO_LEVEL) begin
        // first crossing only arms the detector
        if (armed) begin
          r.status = STATUS_PERIOD;
          r.period = tick_run;
          r.note   = note_for_period(tick_run);
        end
        armed    = 1'b1;
        peak_mag = '0;
        tick_run = '0;
      end
    end
    mag = (s >= ZERO_LEVEL) ? s - ZERO_LEVEL : ZERO_LEVEL - s;
    if (mag > peak_mag) peak_mag = mag;
    last_sample = s;
    r.peak = peak_mag;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Mostly short idles, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int unsigned pick_gap();
    if (!sender_idle_en || $urandom_range(0, 99) < 55) return 0;
    return pick_idle();
  endfunction

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive output stall: long hold first, then random stalls
  always @(posedge clk_i) begin : rx_stall
    logic stall_nxt;
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_nxt = 1'b1;
    end else if (rx_stall_en && $urandom_range(0, 99) < 25) begin
      stall_left = pick_idle() - 1;
      stall_nxt  = 1'b1;
    end else begin
      stall_nxt = 1'b0;
    end
    out_stall_i <= stall_nxt;
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    pitch_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pitch_q.size() == 0) begin
        report_mismatch("unexpected beat, status", status_o, 0);
      end else begin
        want = pending_pitch_q.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (period_o !== want.period) report_mismatch("period", period_o, want.period);
        if (note_o !== want.note) report_mismatch("note", note_o, want.note);
        if (peak_amplitude_o !== want.peak) begin
          report_mismatch("peak", peak_amplitude_o, want.peak);
        end
      end
    end
  end

  // Send one sample beat and record its expected result
  task automatic send_sample(logic [SampleW-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_pitch_q.push_back(track_pitch(s));
  endtask

  // Drop valid, wait for every expected beat, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pitch_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_PERIOD:  min_span = data[CountW-1:0];
      CFG_MAX_PERIOD:  max_span = data[CountW-1:0];
      CFG_SAMPLE_RATE: rate_hz  = data;
      default: ;
    endcase
  endtask

  // Write all registers while idle; junk in the unused upper bits
  task automatic configure(logic [CountW-1:0] lo, logic [CountW-1:0] hi,
                           logic [RateW-1:0] rate);
    logic [RateW-CountW-1:0] junk;
    drain();
    junk = (RateW-CountW)'($urandom_range(0, 15));
    cfg_write(CFG_MIN_PERIOD, {junk, lo});
    junk = (RateW-CountW)'($urandom_range(0, 15));
    cfg_write(CFG_MAX_PERIOD, {junk, hi});
    cfg_write(CFG_SAMPLE_RATE, rate);
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_SPARE, RateW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Wave cycles of random period and amplitude, with some noise beats
  task automatic run_waves(int unsigned pmin, int unsigned pmax, int unsigned n);
    int unsigned sent;
    int unsigned span;
    int unsigned low_len;
    int unsigned amp;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 12) begin
        send_sample(SampleW'($urandom_range(0, 255)));
        sent++;
      end else begin
        span    = $urandom_range(pmin, pmax);
        low_len = $urandom_range(1, span - 1);
        amp     = $urandom_range(1, 128);
        repeat (low_len) send_sample(SampleW'(128 - $urandom_range(1, amp)));
        repeat (span - low_len) begin
          send_sample(SampleW'(128 + $urandom_range(0, (amp > 127) ? 127 : amp)));
        end
        sent += span;
      end
    end
  endtask

  // Sample extremes, first crossing, off-ladder notes, min above max
  task automatic test_directed_edges();
    send_sample(8'd128); send_sample(8'd0);   send_sample(8'd255);
    send_sample(8'd127); send_sample(8'd128); send_sample(8'd1);
    send_sample(8'd254);
    configure(12'd2, 12'd12, 16'd700);
    send_sample(8'd0);   send_sample(8'd200);
    send_sample(8'd100); send_sample(8'd130);
    send_sample(8'd0);   send_sample(8'd0);   send_sample(8'd128);
    configure(12'd6, 12'd3, 16'd8000);
    repeat (6) send_sample(8'd200);
  endtask

  task automatic test_reset_rates();
    configure(MIN_PERIOD_RST, MAX_PERIOD_RST, SAMPLE_RATE_RST);
    sender_idle_en = 1'b1;
    rx_stall_en    = 1'b1;
    run_waves(16, 420, 300);
  endtask

  task automatic test_register_extremes();
    configure(12'd1, 12'd4095, 16'hFFFF);
    run_waves(2, 120, 200);
    configure(12'd1, 12'd2, 16'd1);
    run_waves(2, 6, 150);
  endtask

  task automatic test_min_above_max();
    configure(12'd50, 12'd30, 16'd4000);
    run_waves(2, 60, 200);
  endtask

  task automatic test_note_ladder();
    sender_idle_en = 1'b0;
    rx_stall_en    = 1'b0;
    configure(12'd4, 12'd200, RateW'($urandom_range(2000, 9000)));
    run_waves(20, 130, 200);
    sender_idle_en = 1'b1;
    rx_stall_en    = 1'b1;
    configure(12'd2, 12'd300, RateW'($urandom_range(1, 65535)));
    run_waves(4, 150, 200);
  endtask

  // Hold the output off for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    configure(12'd3, 12'd90, 16'd5000);
    sender_idle_en = 1'b0;
    rx_stall_en    = 1'b0;
    hold_left      = 400;
    run_waves(4, 60, 150);
    sender_idle_en = 1'b1;
    rx_stall_en    = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_reset_rates();
    test_register_extremes();
    test_min_above_max();
    test_note_ladder();
    test_output_backpressure();
    drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/zcpd_pkg.sv
rtl/zcpd_div.sv
rtl/zcpd_track.sv
rtl/zero_crossing_pitch_detector.sv
tb/tb_zero_crossing_pitch_detector.sv
